[rtl/pic_pkg.sv]
// Shared constants, request codes and control types of the platform interrupt controller.
package pic_pkg;

  localparam int PIC_NUM_SOURCES  = 32;
  localparam int PIC_NUM_CONTEXTS = 2;
  localparam int PIC_PRIO_BITS    = 3;

  localparam int REQ_W  = 2;
  localparam int ADDR_W = 26;
  localparam int DATA_W = 32;
  localparam int IRQ_W  = 2;

  localparam logic [REQ_W-1:0] REQ_READ   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd2;

  localparam logic [ADDR_W-1:0] PENDING_BASE  = 26'h000_1000;
  localparam logic [ADDR_W-1:0] ENABLE_BASE   = 26'h000_2000;
  localparam logic [ADDR_W-1:0] ENABLE_STRIDE = 26'h000_0080;
  localparam logic [ADDR_W-1:0] CTX_BASE      = 26'h020_0000;
  localparam logic [ADDR_W-1:0] CTX_STRIDE    = 26'h000_1000;
  localparam logic [11:0]       THRESH_OFF    = 12'h000;
  localparam logic [11:0]       CLAIM_OFF     = 12'h004;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic finish;
  } pic_cmd_t;

endpackage

[rtl/pic_req_if.sv]
// Request channel: one bus access or sample tick with the current source lines.
interface pic_req_if;
  import pic_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic [DATA_W-1:0] source_lines;

  modport source (output valid, req_type, address, write_data, source_lines, input ready);
  modport sink   (input valid, req_type, address, write_data, source_lines, output ready);
endinterface

[rtl/pic_rsp_if.sv]
// Result channel: read data and per-context interrupt lines.
interface pic_rsp_if;
  import pic_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [IRQ_W-1:0]  context_irq;

  modport source (output valid, read_data, context_irq, input ready);
  modport sink   (input valid, read_data, context_irq, output ready);
endinterface

[rtl/platform_interrupt_controller.sv]
// Top level of the platform interrupt controller: sequencer plus datapath.
//
// Each request on in_req is a bus read, a bus write or a sample-only tick, and
// it always carries the current source line levels. Every request yields
// exactly one result on out_rsp: read data (the claimed identifier at a claim
// address, zero for writes, ticks and unmapped reads) and the per-context
// interrupt lines as they stand after the access.
// A request is taken in S_IDLE or S_FINISH, executed in the next cycle
// (S_EXEC), and its result is loaded into the output register in S_FINISH
// once that register is free. The next request is accepted in the same cycle
// as that load, so a new request is taken only as the last one's result is
// handed off; the pace is set by the execute step on the shared register file
// followed by the interrupt evaluation on the updated state.
// The output register parts the two sides: while a result waits for
// out_rsp.ready the block still executes the request in flight; only its
// hand-off, and with it new requests, hold until the receiver takes the old one.
// Synchronous reset clears all priorities, pending and in-service bits,
// enables and thresholds, and leaves both channels idle.
module platform_interrupt_controller import pic_pkg::*; #(
  parameter int NUM_SOURCES  = PIC_NUM_SOURCES,
  parameter int NUM_CONTEXTS = PIC_NUM_CONTEXTS,
  parameter int PRIO_BITS    = PIC_PRIO_BITS
) (
  input logic         clk,
  input logic         rst_n,
  pic_req_if.sink     in_req,
  pic_rsp_if.source   out_rsp
);

  // Command bundle from the sequencer to the datapath.
  pic_cmd_t cmd;

  pic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  // The datapath holds the register file and the result register.
  pic_datapath #(
    .NUM_SOURCES  (NUM_SOURCES),
    .NUM_CONTEXTS (NUM_CONTEXTS),
    .PRIO_BITS    (PRIO_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .req_type     (in_req.req_type),
    .address      (in_req.address),
    .write_data   (in_req.write_data),
    .source_lines (in_req.source_lines),
    .read_data    (out_rsp.read_data),
    .context_irq  (out_rsp.context_irq)
  );

endmodule

[rtl/pic_best.sv]
// Priority selection tree: best eligible source above a threshold, lowest id on ties.
module pic_best import pic_pkg::*; #(
  parameter int NUM_SOURCES = PIC_NUM_SOURCES,
  parameter int PRIO_BITS   = PIC_PRIO_BITS,
  parameter int IW          = $clog2(NUM_SOURCES)
) (
  input  logic [NUM_SOURCES-1:0]                cand,
  input  logic [NUM_SOURCES-1:0][PRIO_BITS-1:0] prio,
  input  logic [PRIO_BITS-1:0]                  thr,
  output logic [IW-1:0]                         id
);

  localparam int LEAVES = 1 << $clog2(NUM_SOURCES);

  logic                 nv [2*LEAVES];
  logic [PRIO_BITS-1:0] np [2*LEAVES];
  logic [IW-1:0]        ni [2*LEAVES];

  assign nv[0] = 1'b0;
  assign np[0] = '0;
  assign ni[0] = '0;

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i > 0 && i < NUM_SOURCES) begin : g_src
      assign nv[LEAVES+i] = cand[i] && (prio[i] > thr);
      assign np[LEAVES+i] = prio[i];
    end else begin : g_none
      assign nv[LEAVES+i] = 1'b0;
      assign np[LEAVES+i] = '0;
    end
    assign ni[LEAVES+i] = IW'(i);
  end

  // Left child covers lower ids, so it wins on equal priority.
  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    logic take_left;
    assign take_left = nv[2*k] && (!nv[2*k+1] || (np[2*k] >= np[2*k+1]));
    assign nv[k] = nv[2*k] || nv[2*k+1];
    assign np[k] = take_left ? np[2*k] : np[2*k+1];
    assign ni[k] = take_left ? ni[2*k] : ni[2*k+1];
  end

  assign id = nv[1] ? ni[1] : '0;

endmodule

[rtl/pic_datapath.sv]
// Register file, gateways, claim/complete logic and result registers.
module pic_datapath import pic_pkg::*; #(
  parameter int NUM_SOURCES  = PIC_NUM_SOURCES,
  parameter int NUM_CONTEXTS = PIC_NUM_CONTEXTS,
  parameter int PRIO_BITS    = PIC_PRIO_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pic_cmd_t          cmd,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] write_data,
  input  logic [DATA_W-1:0] source_lines,
  output logic [DATA_W-1:0] read_data,
  output logic [IRQ_W-1:0]  context_irq
);

  localparam int IW = $clog2(NUM_SOURCES);
  localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam logic [ADDR_W-1:0] ENABLE_END = ENABLE_BASE + ADDR_W'(NUM_CONTEXTS) * ENABLE_STRIDE;
  localparam logic [ADDR_W-1:0] CTX_END    = CTX_BASE + ADDR_W'(NUM_CONTEXTS) * CTX_STRIDE;
  localparam logic [NUM_SOURCES-1:0] SRC_MASK = {{(NUM_SOURCES-1){1'b1}}, 1'b0};

  logic [REQ_W-1:0]       req_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [DATA_W-1:0]      wd_r;
  logic [NUM_SOURCES-1:0] lines_r;

  logic [NUM_SOURCES-1:0][PRIO_BITS-1:0]   prio_r, prio_nxt;
  logic [NUM_SOURCES-1:0]                  pend_r, pend_nxt;
  logic [NUM_SOURCES-1:0]                  insv_r, insv_nxt;
  logic [NUM_CONTEXTS-1:0][NUM_SOURCES-1:0] en_r, en_nxt;
  logic [NUM_CONTEXTS-1:0][PRIO_BITS-1:0]  thr_r, thr_nxt;
  logic [DATA_W-1:0] rd_r, rd_nxt;
  logic [DATA_W-1:0] out_rd_r;
  logic [IRQ_W-1:0]  out_irq_r;

  logic [ADDR_W-1:0]      a, en_off, ctx_off;
  logic [9:0]             word_idx;
  logic [IW-1:0]          src_idx, wd_idx;
  logic [CW-1:0]          en_ctx, ctx_ctx;
  logic [11:0]            ctx_sub;
  logic                   is_rd, is_wr;
  logic                   hit_prio, hit_pend, hit_en, hit_ctx;
  logic [NUM_SOURCES-1:0] pend_s;
  logic [IW-1:0]          claim_id;
  logic [IRQ_W-1:0]       irq;

  assign a        = {addr_r[ADDR_W-1:2], 2'b00};
  assign en_off   = a - ENABLE_BASE;
  assign ctx_off  = a - CTX_BASE;
  assign word_idx = a[11:2];
  assign src_idx  = word_idx[IW-1:0];
  assign wd_idx   = wd_r[IW-1:0];
  assign ctx_sub  = ctx_off[11:0];
  assign is_rd    = (req_r == REQ_READ);
  assign is_wr    = (req_r == REQ_WRITE);

  assign hit_prio = (a < PENDING_BASE);
  assign hit_pend = (a == PENDING_BASE);
  assign hit_en   = (a >= ENABLE_BASE) && (a < ENABLE_END) && (en_off[6:0] == 7'd0);
  assign hit_ctx  = (a >= CTX_BASE) && (a < CTX_END);
  assign en_ctx   = hit_en  ? en_off[7 +: CW]   : '0;
  assign ctx_ctx  = hit_ctx ? ctx_off[12 +: CW] : '0;

  // Level gateways: a high line pends unless the source is in service.
  assign pend_s = pend_r | (lines_r & ~insv_r & SRC_MASK);

  pic_best #(
    .NUM_SOURCES (NUM_SOURCES),
    .PRIO_BITS   (PRIO_BITS)
  ) u_claim (
    .cand (pend_s & en_r[ctx_ctx]),
    .prio (prio_r),
    .thr  (thr_r[ctx_ctx]),
    .id   (claim_id)
  );

  always_comb begin
    prio_nxt = prio_r;
    pend_nxt = pend_s;
    insv_nxt = insv_r;
    en_nxt   = en_r;
    thr_nxt  = thr_r;
    rd_nxt   = '0;
    if (is_rd || is_wr) begin
      if (hit_prio) begin
        if ((word_idx >= 10'd1) && (word_idx < 10'(NUM_SOURCES))) begin
          if (is_wr) begin
            prio_nxt[src_idx] = wd_r[PRIO_BITS-1:0];
          end else begin
            rd_nxt = DATA_W'(prio_r[src_idx]);
          end
        end
      end else if (hit_pend) begin
        if (is_rd) begin
          rd_nxt = DATA_W'(pend_s);
        end
      end else if (hit_en) begin
        if (is_wr) begin
          en_nxt[en_ctx] = wd_r[NUM_SOURCES-1:0] & SRC_MASK;
        end else begin
          rd_nxt = DATA_W'(en_r[en_ctx]);
        end
      end else if (hit_ctx) begin
        if (ctx_sub == THRESH_OFF) begin
          if (is_wr) begin
            thr_nxt[ctx_ctx] = wd_r[PRIO_BITS-1:0];
          end else begin
            rd_nxt = DATA_W'(thr_r[ctx_ctx]);
          end
        end else if (ctx_sub == CLAIM_OFF) begin
          if (is_rd) begin
            if (claim_id != '0) begin
              pend_nxt[claim_id] = 1'b0;
              insv_nxt[claim_id] = 1'b1;
            end
            rd_nxt = DATA_W'(claim_id);
          end else if ((wd_r >= 32'd1) && (wd_r < 32'(NUM_SOURCES))
                       && en_r[ctx_ctx][wd_idx]) begin
            insv_nxt[wd_idx] = 1'b0;
          end
        end
      end
    end
  end

  // Interrupt lines are evaluated on the state left by the access.
  for (genvar c = 0; c < IRQ_W; c++) begin : g_irq
    if (c < NUM_CONTEXTS) begin : g_ctx
      logic [IW-1:0] best_id;
      pic_best #(
        .NUM_SOURCES (NUM_SOURCES),
        .PRIO_BITS   (PRIO_BITS)
      ) u_irq (
        .cand (pend_r & en_r[c]),
        .prio (prio_r),
        .thr  (thr_r[c]),
        .id   (best_id)
      );
      assign irq[c] = (best_id != '0);
    end else begin : g_absent
      assign irq[c] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r <= '0;
      pend_r <= '0;
      insv_r <= '0;
      en_r   <= '0;
      thr_r  <= '0;
    end else if (cmd.exec) begin
      prio_r <= prio_nxt;
      pend_r <= pend_nxt;
      insv_r <= insv_nxt;
      en_r   <= en_nxt;
      thr_r  <= thr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r   <= req_type;
      addr_r  <= address;
      wd_r    <= write_data;
      lines_r <= source_lines[NUM_SOURCES-1:0];
    end
    if (cmd.exec) begin
      rd_r <= rd_nxt;
    end
    if (cmd.finish) begin
      out_rd_r  <= rd_r;
      out_irq_r <= irq;
    end
  end

  assign read_data   = out_rd_r;
  assign context_irq = out_irq_r;

endmodule

[rtl/pic_ctrl.sv]
// Sequencer for the controller: request capture, execute, result hand-off.
module pic_ctrl import pic_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output pic_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (state_r == S_IDLE) || ((state_r == S_FINISH) && out_free);
  assign cmd.load_in = in_valid && in_ready;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.finish  = (state_r == S_FINISH) && out_free;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = in_valid ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> (state_r == S_EXEC))
    else $error("accepted request did not move to execute");

  a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished request produced no result");

  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.exec, cmd.finish}))
    else $error("execute and finish overlap");

  a_exec_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !in_ready)
    else $error("request taken while another executes");
`endif

endmodule
